[design/crcc_pkg.sv]
`default_nettype none
package crcc_pkg;

    localparam int unsigned CRC_W   = 32;
    localparam int unsigned LEN_W   = 32;
    localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'h82f6_3b78;

    // Column n holds the image of bit n.
    typedef logic [CRC_W-1:0][CRC_W-1:0] t_mat;

    typedef struct packed {
        logic [CRC_W-1:0] first_crc;
        logic [CRC_W-1:0] second_crc;
        logic [LEN_W-1:0] second_length;
    } t_req;

    typedef struct packed {
        logic [CRC_W-1:0] combined_crc;
    } t_rsp;

    // What one cell hands to the next.
    typedef struct packed {
        logic             nz;
        logic [CRC_W-1:0] crc;
        logic [CRC_W-1:0] xcrc;
        logic [LEN_W-1:0] len;
    } t_work;

    typedef struct packed {
        logic  valid;
        t_work work;
    } t_cell;

    function automatic logic [CRC_W-1:0] mat_apply(t_mat m, logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] acc;
        acc = '0;
        for (int n = 0; n < CRC_W; n++) begin
            if (v[n]) begin
                acc = acc ^ m[n];
            end
        end
        return acc;
    endfunction

    function automatic t_mat mat_square(t_mat m);
        t_mat t;
        for (int n = 0; n < CRC_W; n++) begin
            t[n] = mat_apply(m, m[n]);
        end
        return t;
    endfunction

    // Zeros operator for 2^k bytes; evaluated at elaboration only.
    function automatic t_mat zeros_op(int unsigned k);
        t_mat op;
        op[0] = CRC_POLY_REFL;
        for (int n = 1; n < CRC_W; n++) begin
            op[n] = CRC_W'(1) << (n - 1);
        end
        // one zero bit squared three times: one zero byte
        for (int s = 0; s < 3; s++) begin
            op = mat_square(op);
        end
        for (int unsigned s = 0; s < k; s++) begin
            op = mat_square(op);
        end
        return op;
    endfunction

endpackage
`default_nettype wire

[design/crcc_if.sv]
`default_nettype none
interface crcc_req_if;
    import crcc_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface crcc_rsp_if;
    import crcc_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/crcc_cell.sv]
`default_nettype none
module crcc_cell #(
    parameter int unsigned K = 0
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire crcc_pkg::t_cell  i_cell,
    output crcc_pkg::t_cell       o_cell,
    input  wire                   i_ready,
    output logic                  o_ready
);
    import crcc_pkg::*;

    localparam t_mat OP = zeros_op(K);

    logic  r_valid;
    t_work r_work;
    t_work n_work;

    // Take a new transfer when empty or when the neighbor drains us.
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_work      = i_cell.work;
        n_work.len  = i_cell.work.len >> 1;
        n_work.nz   = i_cell.work.nz | i_cell.work.len[0];
        if (i_cell.work.len[0]) begin
            n_work.crc = mat_apply(OP, i_cell.work.crc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_cell.valid) begin
            r_work <= n_work;
        end
    end

    assign o_cell.valid = r_valid;
    assign o_cell.work  = r_work;

endmodule
`default_nettype wire

[design/crc32c_combine.sv]
`default_nettype none
// Channel   Dir  Payload                                   Handshake
// i_in      in   first_crc, second_crc, second_length      valid / ready
// o_out     out  combined_crc                              valid / ready
//
// One cell per length bit, each applying the zeros operator for 2^k bytes
// when its bit is set. Throughput is one item per cycle while o_out is ready;
// the row of cells is the only pipeline.
// Reset clears the valid bit of every cell; payload is not reset.
// A stall at o_out backs up cell by cell; i_in.ready drops only once every
// cell holds an item. The last cell is the output register.
module crc32c_combine #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    crcc_req_if.sink   i_in,
    crcc_rsp_if.source o_out
);
    import crcc_pkg::*;

    // w_cell[k] feeds cell k; w_cell[k+1] is its register.
    t_cell w_cell [LENGTH_BITS+1];
    logic  w_rdy  [LENGTH_BITS+1];
    logic [LENGTH_BITS-1:0] w_valids;

    t_cell w_last;

    // Load the first cell straight from the input transfer.
    always_comb begin
        w_cell[0].valid          = i_in.valid;
        w_cell[0].work.nz        = 1'b0;
        w_cell[0].work.crc       = i_in.data.first_crc;
        w_cell[0].work.xcrc      = i_in.data.second_crc;
        w_cell[0].work.len       = i_in.data.second_length;
    end

    assign i_in.ready          = w_rdy[0];
    assign w_rdy[LENGTH_BITS]  = o_out.ready;

    for (genvar k = 0; k < LENGTH_BITS; k++) begin : g_cell
        crcc_cell #(
            .K (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_cell[k]),
            .o_cell  (w_cell[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_ready (w_rdy[k])
        );
        assign w_valids[k] = w_cell[k+1].valid;
    end

    assign w_last = w_cell[LENGTH_BITS];

    // A length that is zero over the active bits passes first_crc through.
    assign o_out.valid             = w_last.valid;
    assign o_out.data.combined_crc = w_last.work.nz
                                   ? (w_last.work.crc ^ w_last.work.xcrc)
                                   : w_last.work.crc;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&w_valids && !o_out.ready))
        else $error("input stalled while a cell is empty");

    a_first_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cell[1].valid |-> i_in.ready)
        else $error("first cell empty but input not ready");

endmodule
`default_nettype wire

[tb/tb_crc32c_combine.sv]
`timescale 1ns / 1ps
module tb_crc32c_combine;
    import crcc_pkg::*;

    // One operator cell per length bit; the instance below uses the same count.
    localparam int unsigned LEN_STAGES   = 32;
    // Drain wait after the last expected result, to catch stray results.
    localparam int unsigned DRAIN_CYCLES = LEN_STAGES + 8;
    // Cycles without any transfer, on either side, before the run is abandoned.
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned N_PHASES     = 5;
    localparam int unsigned RAND_ITEMS   = 270;
    localparam int unsigned N_DIRECTED   = 18;

    // Column n is the image of bit n under the operator.
    typedef logic [CRC_W-1:0][CRC_W-1:0] t_gf2_mat;

    typedef struct {
        logic [CRC_W-1:0] first_crc;
        logic [CRC_W-1:0] second_crc;
        logic [LEN_W-1:0] second_length;
        bit               known;
        logic [CRC_W-1:0] combined_crc;
    } t_combine_row;

    // Directed rows. The combined CRC is typed in only where it is obvious;
    // every other row takes its expectation from the predictor.
    t_combine_row combine_rows [N_DIRECTED] = '{
        // all zero
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        // zero length: lead CRC passes through, trailing CRC is not folded in
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h1234_5678},
        // a zero lead CRC stays zero through any run of zero bytes
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'hA5A5_A5A5, 32'h0000_0001, 1'b1, 32'hA5A5_A5A5},
        '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
        // single-bit leads, single-bit lengths that exercise one cell alone, and many-bit lengths
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0002, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0004, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0100, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0},
        '{32'hDEAD_BEEF, 32'h0F0F_0F0F, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 1'b0, 32'h0}
    };

    // Idle percentages per phase: none, sender, receiver, both, none again.
    int unsigned phase_src_idle [N_PHASES] = '{0, 80, 0, 32, 0};
    int unsigned phase_snk_stall [N_PHASES] = '{0, 0, 80, 32, 0};

    logic i_clk;
    logic i_rst_n;

    crcc_req_if req_if ();
    crcc_rsp_if rsp_if ();

    crc32c_combine #(
        .LENGTH_BITS(LEN_STAGES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_if),
        .o_out  (rsp_if)
    );

    // zero_run_op[k] advances a CRC over 2^k zero bytes.
    t_gf2_mat         zero_run_op [LEN_STAGES];
    logic [CRC_W-1:0] combined_q [$];
    int unsigned      err_cnt       = 0;
    int unsigned      idle_cycles   = 0;
    int unsigned      src_idle_pct  = 0;
    int unsigned      snk_stall_pct = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Sum of the columns selected by the set bits of v.
    function automatic logic [CRC_W-1:0] gf2_apply(t_gf2_mat m, logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] acc;
        acc = '0;
        for (int n = 0; n < CRC_W; n++) begin
            acc = acc ^ (m[n] & {CRC_W{v[n]}});
        end
        return acc;
    endfunction

    // Expected combined CRC: run the lead CRC over the trailing block's length
    // in zero bytes, one operator per set length bit, then fold in the trailer; a zero length returns the lead alone.
    function automatic logic [CRC_W-1:0] combine_crc(logic [CRC_W-1:0] lead,
                                                     logic [CRC_W-1:0] trail,
                                                     logic [LEN_W-1:0] trail_len);
        logic [CRC_W-1:0]      acc;
        logic [LEN_STAGES-1:0] seen_len;
        // only the bits that have a cell count
        seen_len = trail_len[LEN_STAGES-1:0];
        if (seen_len == '0) begin
            return lead;
        end
        acc = lead;
        for (int k = 0; k < LEN_STAGES; k++) begin
            if (seen_len[k]) begin
                acc = gf2_apply(zero_run_op[k], acc);
            end
        end
        return acc ^ trail;
    endfunction

    // Mix of full-range, short, single-bit, shifted and sparse lengths.
    function automatic logic [LEN_W-1:0] pick_length();
        unique case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(16);
            2: return 32'd1 << $urandom_range(31);
            3: return $urandom >> $urandom_range(31);
            default: return $urandom & $urandom;
        endcase
    endfunction

    // Offer one request; enter and leave on a falling edge. Idle first, if the
    // phase says so, then hold valid until the transfer and queue its result.
    task automatic send_request(t_req r, bit known, logic [CRC_W-1:0] typed_crc);
        logic [CRC_W-1:0] want;
        want = known ? typed_crc : combine_crc(r.first_crc, r.second_crc, r.second_length);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = r;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        combined_q.push_back(want);
        @(negedge i_clk);
    endtask

    // Receiver: stall at random per the current phase.
    always @(negedge i_clk) begin
        rsp_if.ready = (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        logic [CRC_W-1:0] want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (combined_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %08h",
                         $time, rsp_if.data.combined_crc);
                err_cnt++;
            end else begin
                want = combined_q.pop_front();
                if (rsp_if.data.combined_crc !== want) begin
                    $display("%0t: combined_crc mismatch, expected %08h, got %08h",
                             $time, want, rsp_if.data.combined_crc);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: abandon the run after too long without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_gf2_mat         op;
        t_gf2_mat         sq;
        logic [CRC_W-1:0] v;
        t_req             r;

        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        i_rst_n      = 1'b0;

        // One zero byte: shift each unit vector through eight reflected steps.
        for (int n = 0; n < CRC_W; n++) begin
            v = CRC_W'(1) << n;
            repeat (8) begin
                v = v[0] ? ((v >> 1) ^ CRC_POLY_REFL) : (v >> 1);
            end
            op[n] = v;
        end
        zero_run_op[0] = op;
        // Square to double the run for each higher length bit.
        for (int k = 1; k < LEN_STAGES; k++) begin
            for (int n = 0; n < CRC_W; n++) begin
                sq[n] = gf2_apply(op, op[n]);
            end
            op             = sq;
            zero_run_op[k] = op;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows, back to back.
        foreach (combine_rows[i]) begin
            r.first_crc     = combine_rows[i].first_crc;
            r.second_crc    = combine_rows[i].second_crc;
            r.second_length = combine_rows[i].second_length;
            send_request(r, combine_rows[i].known, combine_rows[i].combined_crc);
        end

        // Random requests under each idling mix.
        for (int p = 0; p < N_PHASES; p++) begin
            src_idle_pct  = phase_src_idle[p];
            snk_stall_pct = phase_snk_stall[p];
            repeat (RAND_ITEMS) begin
                r.first_crc     = $urandom;
                r.second_crc    = $urandom;
                r.second_length = pick_length();
                send_request(r, 1'b0, '0);
            end
        end
        req_if.valid  = 1'b0;
        snk_stall_pct = 0;

        // Drain: wait for every expected result, then a little longer for strays.
        while (combined_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (combined_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, combined_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
design/crcc_pkg.sv
design/crcc_if.sv
design/crcc_cell.sv
design/crc32c_combine.sv
tb/tb_crc32c_combine.sv
